>>> rtl/core/rounded_rect_pixel_shader_unit_assert.svh
// Assertion macros used by the checker module of the pixel shader.
`ifndef ROUNDED_RECT_PIXEL_SHADER_UNIT_ASSERT_SVH
`define ROUNDED_RECT_PIXEL_SHADER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRPS_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("pixel shader assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RRPS_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("pixel shader assertion failed");

`endif

>>> rtl/core/rrps_pkg.sv
`timescale 1ns / 1ps

package rrps_pkg;

    localparam int SCREEN_WIDTH      = 240;
    localparam int SCREEN_HEIGHT     = 240;
    localparam int CORNER_TABLE_SIZE = 16;

    localparam logic signed [13:0] SCREEN_W_S = 14'(SCREEN_WIDTH);
    localparam logic signed [13:0] SCREEN_H_S = 14'(SCREEN_HEIGHT);

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Truncating division by 15 as a multiply by 2185 and a shift by 15;
    // exact for every sum below 1024.
    localparam logic [21:0] DIV15_RECIP = 22'd2185;
    localparam int          DIV15_SHIFT = 15;

    localparam logic [3:0] LEVEL_FULL = 4'd15;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ORIGIN_X      = 3'd0,
        CFG_ORIGIN_Y      = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_FILL_COLOR    = 3'd4,
        CFG_BACK_COLOR    = 3'd5,
        CFG_RADIUS        = 3'd6
    } rrps_cfg_idx_t;

    typedef struct packed {
        logic [7:0] screen_col;
        logic [7:0] screen_row;
    } rrps_in_t;

    typedef struct packed {
        logic [15:0] pixel_color;
        logic        pixel_valid;
    } rrps_out_t;

    localparam logic [3:0] COVERAGE [CORNER_TABLE_SIZE*CORNER_TABLE_SIZE] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd1, 4'd5, 4'd9, 4'd12, 4'd14, 4'd15,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd3, 4'd9, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd8,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd3, 4'd12, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd0, 4'd0, 4'd0, 4'd0, 4'd3, 4'd14, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd0, 4'd0, 4'd0, 4'd3, 4'd14, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd0, 4'd0, 4'd0, 4'd12, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd0, 4'd0, 4'd8, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd0, 4'd3, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd0, 4'd9, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd1, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd5, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd9, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd12, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd14, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15,
        4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15
    };

endpackage

>>> rtl/core/rounded_rect_pixel_shader_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// pixel     in         pix_valid/stall    rrps_in_t  (screen_col, screen_row)
// result    out        res_valid/stall    rrps_out_t (pixel_color, pixel_valid)
// config    in         cfg_valid/ready    cfg_index, cfg_data
//
// A pixel passes through every stage in order, and one pixel can enter every cycle while pix_stall is low.
// The five stages are window test, corner select, coverage lookup, blend sums and divide.
// Reset clears the valid bits and sets the configuration registers to their defaults, radius 16.
// A stall on the result side holds only the stages that carry data; empty stages still fill.
// Configuration writes are always taken, since cfg_ready is tied high.
module rounded_rect_pixel_shader_unit
    import rrps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  rrps_in_t               pix_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output rrps_out_t              res_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [11:0] origin_x_reg;
    logic [11:0] origin_y_reg;
    logic [10:0] rect_width_reg;
    logic [10:0] rect_height_reg;
    logic [15:0] fill_color_reg;
    logic [15:0] back_color_reg;
    logic [7:0]  radius_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s1_adv, s2_adv, s3_adv, s4_adv, s5_adv;

    logic [10:0] s1_rx_reg, s1_rx_next;
    logic [10:0] s1_ry_reg, s1_ry_next;
    logic        s1_ok_reg, s1_ok_next;

    logic [3:0]  s2_cx_reg, s2_cx_next;
    logic [3:0]  s2_cy_reg, s2_cy_next;
    logic        s2_corner_reg, s2_corner_next;
    logic        s2_ok_reg;

    logic [3:0]  s3_level_reg, s3_level_next;
    logic        s3_corner_reg;
    logic        s3_ok_reg;

    logic [9:0]  s4_sr_reg, s4_sr_next;
    logic [9:0]  s4_sg_reg, s4_sg_next;
    logic [9:0]  s4_sb_reg, s4_sb_next;
    logic        s4_corner_reg;
    logic        s4_ok_reg;

    rrps_out_t   res_data_reg, res_data_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            rect_width_reg  <= '0;
            rect_height_reg <= '0;
            fill_color_reg  <= '0;
            back_color_reg  <= '0;
            radius_reg      <= 8'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (rrps_cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X:    origin_x_reg    <= cfg_data[11:0];
                CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data[11:0];
                CFG_RECT_WIDTH:  rect_width_reg  <= cfg_data[10:0];
                CFG_RECT_HEIGHT: rect_height_reg <= cfg_data[10:0];
                CFG_FILL_COLOR:  fill_color_reg  <= cfg_data;
                CFG_BACK_COLOR:  back_color_reg  <= cfg_data;
                CFG_RADIUS:      radius_reg      <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its successor moves on.
    assign s5_adv    = !s5_valid_reg || !res_stall;
    assign s4_adv    = !s4_valid_reg || s5_adv;
    assign s3_adv    = !s3_valid_reg || s4_adv;
    assign s2_adv    = !s2_valid_reg || s3_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign pix_stall = !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= pix_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_adv)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_adv)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Stage 1: window test against the screen-clamped rectangle, and a check that the radius is 2, 4, 8 or 16.
    logic signed [13:0] col_s, row_s, x_s, y_s, x_end, y_end, rx_full, ry_full;
    logic               in_x, in_y, rad_ok;

    always_comb
    begin
        col_s   = signed'({6'b0, pix_data.screen_col});
        row_s   = signed'({6'b0, pix_data.screen_row});
        x_s     = signed'({{2{origin_x_reg[11]}}, origin_x_reg});
        y_s     = signed'({{2{origin_y_reg[11]}}, origin_y_reg});
        x_end   = x_s + signed'({3'b0, rect_width_reg}) - 14'sd1;
        y_end   = y_s + signed'({3'b0, rect_height_reg}) - 14'sd1;
        rx_full = col_s - x_s;
        ry_full = row_s - y_s;
        in_x    = (col_s >= x_s) && (col_s <= x_end) && (col_s < SCREEN_W_S);
        in_y    = (row_s >= y_s) && (row_s <= y_end) && (row_s < SCREEN_H_S);
        rad_ok  = (radius_reg == 8'd2) || (radius_reg == 8'd4)
               || (radius_reg == 8'd8) || (radius_reg == 8'd16);
        s1_rx_next = rx_full[10:0];
        s1_ry_next = ry_full[10:0];
        s1_ok_next = in_x && in_y && rad_ok;
    end

    // Stage 2: pick the corner, top-left first, then bottom-left, top-right, bottom-right.
    logic [4:0]         rad5;
    logic signed [12:0] w_minus_rad, h_minus_rad;
    logic               near_left, near_right, near_top, near_bottom;
    logic [10:0]        mirror_x, mirror_y;

    always_comb
    begin
        rad5        = radius_reg[4:0];
        w_minus_rad = signed'({2'b00, rect_width_reg}) - signed'({8'b0, rad5});
        h_minus_rad = signed'({2'b00, rect_height_reg}) - signed'({8'b0, rad5});
        near_left   = s1_rx_reg < {6'b0, rad5};
        near_top    = s1_ry_reg < {6'b0, rad5};
        near_right  = signed'({2'b00, s1_rx_reg}) >= w_minus_rad;
        near_bottom = signed'({2'b00, s1_ry_reg}) >= h_minus_rad;
        mirror_x    = rect_width_reg - 11'd1 - s1_rx_reg;
        mirror_y    = rect_height_reg - 11'd1 - s1_ry_reg;
        s2_cx_next  = near_left ? s1_rx_reg[3:0] : mirror_x[3:0];
        s2_cy_next  = near_top ? s1_ry_reg[3:0] : mirror_y[3:0];
        s2_corner_next = (near_left || near_right) && (near_top || near_bottom);
    end

    // Stage 3: coverage lookup with a stride of sixteen over the radius.
    logic [1:0] stride_shift;
    logic [3:0] tab_col, tab_row;

    always_comb
    begin
        unique case (radius_reg)
            8'd2:    stride_shift = 2'd3;
            8'd4:    stride_shift = 2'd2;
            8'd8:    stride_shift = 2'd1;
            default: stride_shift = 2'd0;
        endcase
        tab_col       = s2_cx_reg << stride_shift;
        tab_row       = s2_cy_reg << stride_shift;
        s3_level_next = COVERAGE[{tab_row, tab_col}];
    end

    // Stage 4: weighted channel sums of fill and background.
    logic [3:0] level_inv;

    always_comb
    begin
        level_inv  = LEVEL_FULL - s3_level_reg;
        s4_sr_next = 10'(fill_color_reg[15:11]) * 10'(s3_level_reg)
                   + 10'(back_color_reg[15:11]) * 10'(level_inv);
        s4_sg_next = 10'(fill_color_reg[10:5]) * 10'(s3_level_reg)
                   + 10'(back_color_reg[10:5]) * 10'(level_inv);
        s4_sb_next = 10'(fill_color_reg[4:0]) * 10'(s3_level_reg)
                   + 10'(back_color_reg[4:0]) * 10'(level_inv);
    end

    // Stage 5: divide each sum by 15 and choose the final color.
    logic [21:0] quot_r, quot_g, quot_b;
    logic [15:0] blended;

    always_comb
    begin
        quot_r  = 22'(s4_sr_reg) * DIV15_RECIP;
        quot_g  = 22'(s4_sg_reg) * DIV15_RECIP;
        quot_b  = 22'(s4_sb_reg) * DIV15_RECIP;
        blended = {quot_r[DIV15_SHIFT +: 5], quot_g[DIV15_SHIFT +: 6],
                   quot_b[DIV15_SHIFT +: 5]};
        res_data_next.pixel_valid = s4_ok_reg;
        if (!s4_ok_reg)
        begin
            res_data_next.pixel_color = '0;
        end
        else if (s4_corner_reg)
        begin
            res_data_next.pixel_color = blended;
        end
        else
        begin
            res_data_next.pixel_color = fill_color_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_rx_reg <= s1_rx_next;
            s1_ry_reg <= s1_ry_next;
            s1_ok_reg <= s1_ok_next;
        end
        if (s2_adv)
        begin
            s2_cx_reg     <= s2_cx_next;
            s2_cy_reg     <= s2_cy_next;
            s2_corner_reg <= s2_corner_next;
            s2_ok_reg     <= s1_ok_reg;
        end
        if (s3_adv)
        begin
            s3_level_reg  <= s3_level_next;
            s3_corner_reg <= s2_corner_reg;
            s3_ok_reg     <= s2_ok_reg;
        end
        if (s4_adv)
        begin
            s4_sr_reg     <= s4_sr_next;
            s4_sg_reg     <= s4_sg_next;
            s4_sb_reg     <= s4_sb_next;
            s4_corner_reg <= s3_corner_reg;
            s4_ok_reg     <= s3_ok_reg;
        end
        if (s5_adv)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign res_valid = s5_valid_reg;
    assign res_data  = res_data_reg;

endmodule

>>> rtl/core/rrps_checker.sv
`timescale 1ns / 1ps
`include "rounded_rect_pixel_shader_unit_assert.svh"

module rrps_checker
    import rrps_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      pix_stall,
    input logic      res_valid,
    input logic      res_stall,
    input rrps_out_t res_data
);

    logic res_held;
    logic res_blank;

    assign res_held  = res_valid && res_stall;
    assign res_blank = res_valid && !res_data.pixel_valid;

    // A stalled result keeps its valid and its payload.
    `RRPS_ASSERT_NEXT(a_res_hold, clk, rst_n, res_held, res_valid && $stable(res_data))

    // A result that is not pixel_valid (outside the window or with a bad radius) carries a black color.
    `RRPS_ASSERT_SAME(a_invalid_black, clk, rst_n, res_blank, res_data.pixel_color == 16'd0)

    // When the result side moves or is empty, the whole pipeline moves and can take a pixel.
    `RRPS_ASSERT_SAME(a_no_stall_when_free, clk, rst_n, !res_held, !pix_stall)

endmodule

bind rounded_rect_pixel_shader_unit rrps_checker u_rrps_checker (.*);

>>> bench/tb_rounded_rect_pixel_shader_unit.sv
`timescale 1ns / 1ps

module tb_rounded_rect_pixel_shader_unit;
    import rrps_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int QUIET_LIMIT = 1000;
    localparam int TAIL_CYCLES = 12;
    localparam int SCREEN_COLS = 240;
    localparam int SCREEN_ROWS = 240;
    localparam int COVER_SIDE  = 16;
    localparam int FULL_LEVEL  = 15;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_PIXELS  = 73;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    typedef struct {
        rrps_in_t  pix;
        rrps_out_t want;
    } shade_expect_t;

    class shade_checker;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [15:0] fill_color;
        logic [15:0] back_color;
        logic [7:0]  radius;
        shade_expect_t expected_pixels[$];
        int mismatches;
        int results_checked;

        function new();
            origin_x = '0;
            origin_y = '0;
            rect_width = '0;
            rect_height = '0;
            fill_color = '0;
            back_color = '0;
            radius = 8'd16;
            mismatches = 0;
            results_checked = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
            case (idx)
                CFG_ORIGIN_X:    origin_x = value[11:0];
                CFG_ORIGIN_Y:    origin_y = value[11:0];
                CFG_RECT_WIDTH:  rect_width = value[10:0];
                CFG_RECT_HEIGHT: rect_height = value[10:0];
                CFG_FILL_COLOR:  fill_color = value;
                CFG_BACK_COLOR:  back_color = value;
                CFG_RADIUS:      radius = value[7:0];
                default:         ;
            endcase
        endfunction

        function logic [3:0] coverage_level(int idx);
            logic [63:0] row_bits;
            case (idx / COVER_SIDE)
                0:       row_bits = 64'h0000000000159CEF;
                1:       row_bits = 64'h0000000039FFFFFF;
                2:       row_bits = 64'h00000008FFFFFFFF;
                3:       row_bits = 64'h000003CFFFFFFFFF;
                4:       row_bits = 64'h00003EFFFFFFFFFF;
                5:       row_bits = 64'h0003EFFFFFFFFFFF;
                6:       row_bits = 64'h000CFFFFFFFFFFFF;
                7:       row_bits = 64'h008FFFFFFFFFFFFF;
                8:       row_bits = 64'h03FFFFFFFFFFFFFF;
                9:       row_bits = 64'h09FFFFFFFFFFFFFF;
                10:      row_bits = 64'h1FFFFFFFFFFFFFFF;
                11:      row_bits = 64'h5FFFFFFFFFFFFFFF;
                12:      row_bits = 64'h9FFFFFFFFFFFFFFF;
                13:      row_bits = 64'hCFFFFFFFFFFFFFFF;
                14:      row_bits = 64'hEFFFFFFFFFFFFFFF;
                default: row_bits = 64'hFFFFFFFFFFFFFFFF;
            endcase
            return row_bits[63 - 4 * (idx % COVER_SIDE) -: 4];
        endfunction

        function logic [15:0] blend(logic [3:0] level);
            int l;
            int r;
            int g;
            int b;
            l = level;
            r = (fill_color[15:11] * l + back_color[15:11] * (FULL_LEVEL - l)) / FULL_LEVEL;
            g = (fill_color[10:5] * l + back_color[10:5] * (FULL_LEVEL - l)) / FULL_LEVEL;
            b = (fill_color[4:0] * l + back_color[4:0] * (FULL_LEVEL - l)) / FULL_LEVEL;
            return {r[4:0], g[5:0], b[4:0]};
        endfunction

        function rrps_out_t shade(rrps_in_t p);
            int x;
            int y;
            int w;
            int h;
            int rad;
            int col;
            int row;
            int x0;
            int y0;
            int x1;
            int y1;
            int rx;
            int ry;
            int cx;
            int cy;
            int stride;
            int cov_idx;
            bit corner;
            rrps_out_t r;
            r = '0;
            x = int'($signed(origin_x));
            y = int'($signed(origin_y));
            w = rect_width;
            h = rect_height;
            rad = radius;
            col = p.screen_col;
            row = p.screen_row;
            if (rad != 2 && rad != 4 && rad != 8 && rad != 16)
                return r;
            stride = COVER_SIDE / rad;
            x0 = (x > 0) ? x : 0;
            y0 = (y > 0) ? y : 0;
            x1 = (x + w - 1 < SCREEN_COLS - 1) ? x + w - 1 : SCREEN_COLS - 1;
            y1 = (y + h - 1 < SCREEN_ROWS - 1) ? y + h - 1 : SCREEN_ROWS - 1;
            if (col < x0 || col > x1 || row < y0 || row > y1)
                return r;
            rx = col - x;
            ry = row - y;
            cx = 0;
            cy = 0;
            corner = 1'b1;
            if (rx < rad && ry < rad)
            begin
                cx = rx;
                cy = ry;
            end
            else if (rx < rad && ry >= h - rad)
            begin
                cx = rx;
                cy = h - 1 - ry;
            end
            else if (rx >= w - rad && ry < rad)
            begin
                cx = w - 1 - rx;
                cy = ry;
            end
            else if (rx >= w - rad && ry >= h - rad)
            begin
                cx = w - 1 - rx;
                cy = h - 1 - ry;
            end
            else
            begin
                corner = 1'b0;
            end
            if (corner)
            begin
                cov_idx = (cx * stride + cy * stride * COVER_SIDE) & 255;
                r.pixel_color = blend(coverage_level(cov_idx));
            end
            else
                r.pixel_color = fill_color;
            r.pixel_valid = 1'b1;
            return r;
        endfunction

        function void note_pixel(rrps_in_t p);
            shade_expect_t e;
            e.pix = p;
            e.want = shade(p);
            expected_pixels.push_back(e);
        endfunction

        function void check_result(rrps_out_t got);
            shade_expect_t e;
            results_checked++;
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected result: color %h valid %b with no pixel pending.",
                             got.pixel_color, got.pixel_valid);
                return;
            end
            e = expected_pixels.pop_front();
            if (got.pixel_color !== e.want.pixel_color || got.pixel_valid !== e.want.pixel_valid)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Pixel (%0d,%0d): expected color %h valid %b, got color %h valid %b.",
                             e.pix.screen_col, e.pix.screen_row, e.want.pixel_color,
                             e.want.pixel_valid, got.pixel_color, got.pixel_valid);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   pix_valid;
    logic                   pix_stall;
    rrps_in_t               pix_data;
    logic                   res_valid;
    logic                   res_stall;
    rrps_out_t              res_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    shade_checker board;
    bit sender_idles;
    bit receiver_stalls;
    int stall_left;
    int quiet_cycles;
    int pixels_sent;
    int setups;

    rounded_rect_pixel_shader_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (pix_valid && !pix_stall)
                board.note_pixel(pix_data);
            if (res_valid && !res_stall)
                board.check_result(res_data);
            if (cfg_valid && cfg_ready)
                board.write_register(cfg_index, cfg_data);
        end
    end

    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles.", QUIET_LIMIT);
            $display("tb_rounded_rect_pixel_shader_unit: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_stall = 1'b1;
            stall_left--;
        end
        else
        begin
            res_stall = 1'b0;
            if (receiver_stalls && $urandom_range(0, 3) == 0)
                stall_left = $urandom_range(1, 3);
        end
    end

    task automatic wait_for_results();
        @(negedge clk);
        pix_valid = 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_register(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
        wait_for_results();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_window(logic [15:0] ox, logic [15:0] oy, logic [15:0] w, logic [15:0] h,
                              logic [15:0] fill, logic [15:0] back, logic [15:0] rad);
        set_register(CFG_ORIGIN_X, ox);
        set_register(CFG_ORIGIN_Y, oy);
        set_register(CFG_RECT_WIDTH, w);
        set_register(CFG_RECT_HEIGHT, h);
        set_register(CFG_FILL_COLOR, fill);
        set_register(CFG_BACK_COLOR, back);
        set_register(CFG_RADIUS, rad);
        setups++;
    endtask

    task automatic send_pixel(int col, int row);
        @(negedge clk);
        if (sender_idles && $urandom_range(0, 4) == 0)
        begin
            pix_valid = 1'b0;
            pix_data = rrps_in_t'($urandom);
            repeat ($urandom_range(1, 3))
                @(negedge clk);
        end
        pix_valid = 1'b1;
        pix_data.screen_col = col[7:0];
        pix_data.screen_row = row[7:0];
        do
            @(posedge clk);
        while (pix_stall);
        pixels_sent++;
    endtask

    function automatic int pick_offset(int span, int rad);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6)
        begin
            if ($urandom_range(0, 1) == 1)
                return int'($urandom_range(0, rad + 1));
            return span - 1 - int'($urandom_range(0, rad + 1));
        end
        if (mode < 8)
            return int'($urandom_range(0, span));
        return -10000;
    endfunction

    task automatic send_random_pixel();
        int x;
        int y;
        int col;
        int row;
        int rad;
        x = int'($signed(board.origin_x));
        y = int'($signed(board.origin_y));
        rad = board.radius;
        col = x + pick_offset(board.rect_width, rad);
        row = y + pick_offset(board.rect_height, rad);
        if (col < 0 || col > 255)
            col = $urandom_range(0, 255);
        if (row < 0 || row > 255)
            row = $urandom_range(0, 255);
        send_pixel(col, row);
    endtask

    function automatic logic [11:0] random_origin();
        case ($urandom_range(0, 9))
            0:       return 12'h800;
            1:       return 12'h7FF;
            2:       return 12'($urandom);
            default: return 12'(int'($urandom_range(0, 220)) - 20);
        endcase
    endfunction

    function automatic logic [10:0] random_extent();
        case ($urandom_range(0, 9))
            0:       return 11'd0;
            1:       return 11'd2047;
            2:       return 11'($urandom_range(1, 2047));
            3:       return 11'($urandom_range(1, 4));
            default: return 11'($urandom_range(8, 90));
        endcase
    endfunction

    function automatic logic [15:0] random_color();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_radius();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        return 8'(1 << $urandom_range(1, 4));
    endfunction

    initial
    begin
        board = new();
        rst_n = 1'b0;
        pix_valid = 1'b0;
        pix_data = '0;
        res_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        stall_left = 0;
        quiet_cycles = 0;
        pixels_sent = 0;
        setups = 0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_pixel(0, 0);
        send_pixel(255, 255);

        set_window(16'(-5), 16'(-3), 16'd250, 16'd250, 16'hF81F, 16'h07E0, 16'd16);
        send_pixel(0, 0);
        send_pixel(239, 239);
        send_pixel(240, 10);
        send_pixel(10, 240);
        send_pixel(255, 255);
        send_pixel(5, 5);
        send_pixel(20, 3);
        send_pixel(230, 230);
        send_pixel(120, 120);

        set_window(16'd100, 16'd50, 16'd3, 16'd5, 16'hFFFF, 16'h0000, 16'd4);
        send_pixel(100, 50);
        send_pixel(102, 54);
        send_pixel(101, 52);
        send_pixel(99, 50);
        send_pixel(103, 54);
        send_pixel(100, 54);

        set_register(CFG_RADIUS, 16'd5);
        send_pixel(101, 52);
        set_register(CFG_RADIUS, 16'd0);
        send_pixel(101, 52);
        set_register(CFG_RADIUS, 16'hFFFF);
        send_pixel(101, 52);

        set_window(16'h07FF, 16'hF800, 16'd2047, 16'd2047, 16'hABCD, 16'h1234, 16'd2);
        send_pixel(239, 0);
        send_pixel(0, 239);
        set_window(16'hF800, 16'd0, 16'd2047, 16'd2047, 16'h5555, 16'hAAAA, 16'd2);
        send_pixel(0, 0);
        set_register(CFG_SPARE_INDEX, 16'hFFFF);
        send_pixel(0, 0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_window({4'($urandom), random_origin()}, {4'($urandom), random_origin()},
                       {5'($urandom), random_extent()}, {5'($urandom), random_extent()},
                       random_color(), random_color(), {8'($urandom), random_radius()});
            if (phase == RANDOM_PHASES - 1)
            begin
                sender_idles = 1'b0;
                receiver_stalls = 1'b0;
            end
            else
            begin
                sender_idles = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
            end
            repeat (PHASE_PIXELS)
                send_random_pixel();
        end

        wait_for_results();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("Covered %0d pixels over %0d window setups; %0d results checked, %0d mismatches.",
                 pixels_sent, setups, board.results_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_rounded_rect_pixel_shader_unit: PASS");
        else
            $display("tb_rounded_rect_pixel_shader_unit: FAIL");
        $finish;
    end

endmodule
